>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_AT(lbl, clk, rstn, prop)

`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

>>> design/u8d_pkg.sv
// ---------------------------------------------------------------------------
// u8d_pkg
// shared types and constants of the utf-8 stream decoder
// ---------------------------------------------------------------------------
package u8d_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned LenW   = 3;
  localparam int unsigned SixW   = 6;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;

  localparam logic [LenW-1:0] LenOne   = 3'd1;
  localparam logic [LenW-1:0] LenTwo   = 3'd2;
  localparam logic [LenW-1:0] LenThree = 3'd3;
  localparam logic [LenW-1:0] LenFour  = 3'd4;

  localparam logic [1:0] LeftNone  = 2'd0;
  localparam logic [1:0] LeftOne   = 2'd1;
  localparam logic [1:0] LeftTwo   = 2'd2;
  localparam logic [1:0] LeftThree = 2'd3;

  localparam logic [1:0] ContMarker = 2'b10;

  typedef enum logic [1:0] {
    OP_LEAD,
    OP_CONT,
    OP_SINGLE
  } op_kind_e;

  // one classified byte on its way to the back end
  typedef struct packed {
    op_kind_e             kind;
    logic [ByteW-1:0]     data;
    logic [LenW-1:0]      len;
    logic                 flag;  // stray lead or bad marker
    logic                 last;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } q_push_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } q_head_t;

endpackage

>>> design/u8d_stream_if.sv
// ---------------------------------------------------------------------------
// u8d_stream_if
// byte input channel and code point output channel
// ---------------------------------------------------------------------------
interface u8d_byte_if
  import u8d_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface u8d_cp_if
  import u8d_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [CpW-1:0]  code_point;
  logic [LenW-1:0] char_length;
  logic            stray_lead;
  logic            bad_continuation;

  modport source (output valid, output code_point, output char_length,
                  output stray_lead, output bad_continuation, input ready);
  modport sink   (input valid, input code_point, input char_length,
                  input stray_lead, input bad_continuation, output ready);
endinterface

>>> design/u8d_front.sv
// ---------------------------------------------------------------------------
// u8d_front
// accepts bytes, tracks expected follow bytes and classifies each item
// ---------------------------------------------------------------------------
module u8d_front
  import u8d_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  u8d_byte_if.sink   byte_i,
  input  logic       q_full_i,
  output q_push_t    q_push_o
);

  logic [1:0]       left_q, left_d;
  logic [ByteW-1:0] b;
  logic             accept;
  op_t              op;

  assign b            = byte_i.byte_in;
  assign byte_i.ready = !q_full_i;
  assign accept       = byte_i.valid && !q_full_i;

  always_comb begin
    left_d  = left_q;
    op.kind = OP_SINGLE;
    op.data = b;
    op.len  = LenOne;
    op.flag = 1'b0;
    op.last = 1'b0;
    if (left_q == LeftNone) begin
      priority if (b[7:5] == 3'b110) begin
        op.kind = OP_LEAD;
        op.data = {3'b000, b[4:0]};
        op.len  = LenTwo;
        left_d  = LeftOne;
      end else if (b[7:4] == 4'b1110) begin
        op.kind = OP_LEAD;
        op.data = {4'b0000, b[3:0]};
        op.len  = LenThree;
        left_d  = LeftTwo;
      end else if (b[7:3] == 5'b11110) begin
        op.kind = OP_LEAD;
        op.data = {5'b00000, b[2:0]};
        op.len  = LenFour;
        left_d  = LeftThree;
      end else begin
        op.kind = OP_SINGLE;
        op.flag = (b[7:6] == ContMarker);
      end
    end else begin
      op.kind = OP_CONT;
      op.data = {2'b00, b[SixW-1:0]};
      op.flag = (b[7:6] != ContMarker);
      op.last = (left_q == LeftOne);
      left_d  = left_q - LeftOne;
    end
  end

  assign q_push_o.valid = accept;
  assign q_push_o.op    = op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= LeftNone;
    end else if (accept) begin
      left_q <= left_d;
    end
  end

endmodule

>>> design/u8d_queue.sv
// ---------------------------------------------------------------------------
// u8d_queue
// two-entry queue between the front and back ends
// ---------------------------------------------------------------------------
module u8d_queue
  import u8d_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_push_t push_i,
  output logic    full_o,
  output q_head_t head_o,
  input  logic    pop_i
);

  op_t                  mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q;
  logic                 do_push, do_pop;

  assign full_o       = (cnt_q == QueueCntW'(QueueDepth));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.op    = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_o.valid;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.op;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

>>> design/u8d_back.sv
// ---------------------------------------------------------------------------
// u8d_back
// accumulates payload bits and holds the result register
// ---------------------------------------------------------------------------
module u8d_back
  import u8d_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  q_head_t  head_i,
  output logic     pop_o,
  u8d_cp_if.source cp_o
);

  logic [CpW-1:0]  acc_q, acc_d, acc_shift;
  logic [LenW-1:0] len_q, len_d;
  logic            bad_q, bad_d, bad_next;
  logic            emit;
  logic            out_free;

  logic            out_valid_q;
  logic [CpW-1:0]  out_cp_q, out_cp_d;
  logic [LenW-1:0] out_len_q, out_len_d;
  logic            out_stray_q, out_stray_d;
  logic            out_bad_q, out_bad_d;

  assign acc_shift = {acc_q[CpW-SixW-1:0], head_i.op.data[SixW-1:0]};
  assign bad_next  = bad_q | head_i.op.flag;
  assign emit      = (head_i.op.kind == OP_SINGLE)
                  || (head_i.op.kind == OP_CONT && head_i.op.last);
  assign out_free  = !out_valid_q || cp_o.ready;
  assign pop_o     = head_i.valid && (!emit || out_free);

  always_comb begin
    acc_d       = acc_q;
    len_d       = len_q;
    bad_d       = bad_q;
    out_cp_d    = {{(CpW-ByteW){1'b0}}, head_i.op.data};
    out_len_d   = LenOne;
    out_stray_d = 1'b0;
    out_bad_d   = 1'b0;
    unique case (head_i.op.kind)
      OP_LEAD: begin
        acc_d = {{(CpW-ByteW){1'b0}}, head_i.op.data};
        len_d = head_i.op.len;
        bad_d = 1'b0;
      end
      OP_CONT: begin
        out_cp_d  = acc_shift;
        out_len_d = len_q;
        out_bad_d = bad_next;
        if (head_i.op.last) begin
          acc_d = '0;
          len_d = LenOne;
          bad_d = 1'b0;
        end else begin
          acc_d = acc_shift;
          bad_d = bad_next;
        end
      end
      OP_SINGLE: begin
        out_stray_d = head_i.op.flag;
      end
      default: begin
        acc_d = acc_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      len_q       <= LenOne;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        acc_q <= acc_d;
        len_q <= len_d;
        bad_q <= bad_d;
      end
      if (pop_o && emit) begin
        out_valid_q <= 1'b1;
      end else if (cp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) begin
      out_cp_q    <= out_cp_d;
      out_len_q   <= out_len_d;
      out_stray_q <= out_stray_d;
      out_bad_q   <= out_bad_d;
    end
  end

  assign cp_o.valid            = out_valid_q;
  assign cp_o.code_point       = out_cp_q;
  assign cp_o.char_length      = out_len_q;
  assign cp_o.stray_lead       = out_stray_q;
  assign cp_o.bad_continuation = out_bad_q;

endmodule

>>> design/utf8_stream_decoder.sv
// ---------------------------------------------------------------------------
// utf8_stream_decoder
// utf-8 byte stream to code point decoder
// ---------------------------------------------------------------------------
// Takes one byte per item and sustains one item per clock cycle; the only
// thing that slows the input is back-pressure on the code point channel once
// the two-entry queue between front and back end and the result register are
// full. A result is offered once the last byte of its character has been accepted
// into the queue and then moved from the queue into the result register. Lead
// bytes 110xxxxx, 1110xxxx and 11110xxx open 2-, 3- and 4-byte characters; every
// other lead byte is passed through unsigned with length 1, and a 10xxxxxx lead
// sets stray_lead. Following bytes always contribute their low six bits; a wrong
// marker sets bad_continuation for that character.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module utf8_stream_decoder
  import u8d_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  u8d_byte_if.sink byte_i,
  u8d_cp_if.source cp_o
);

  q_push_t q_push;
  q_head_t q_head;
  logic    q_full;
  logic    q_pop;
  logic    cp_single;
  logic    cp_narrow;

  u8d_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_i),
    .q_full_i (q_full),
    .q_push_o (q_push)
  );

  u8d_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .full_o (q_full),
    .head_o (q_head),
    .pop_i  (q_pop)
  );

  u8d_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (q_head),
    .pop_o  (q_pop),
    .cp_o   (cp_o)
  );

  assign cp_single = cp_o.valid && (cp_o.char_length == LenOne);
  assign cp_narrow = (cp_o.code_point[CpW-1:ByteW] == '0);

  `ASSERT_NEVER(a_push_full, clk_i, rst_ni, q_push.valid && q_full)
  `ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, q_pop && !q_head.valid)
  `ASSERT_NEVER(a_stray_multi, clk_i, rst_ni, cp_o.valid && cp_o.stray_lead && !cp_single)
  `ASSERT_AT(a_single_narrow, clk_i, rst_ni, cp_single |-> (cp_narrow && !cp_o.bad_continuation))

endmodule

>>> verif/tb_utf8_stream_decoder.sv
// ---------------------------------------------------------------------------
// tb_utf8_stream_decoder
// self-checking testbench of the utf-8 stream decoder
// ---------------------------------------------------------------------------
// A short table of directed bytes covers single bytes at the extremes, stray
// continuation leads, 11111xxx leads, the smallest 2-byte character, the
// largest 3- and 4-byte characters, a bad marker and a lead byte inside a
// character. Random characters follow: mostly well-formed 1- to 4-byte
// characters with random payload, plus random lone bytes and sequences
// with random following bytes. Each accepted byte goes through a decoder
// model in the testbench; every code point item is checked field by field
// against the oldest pending character. The run goes through phases with no
// idling, sender gaps, receiver stalls and both, and drains between phases.
// ---------------------------------------------------------------------------
module tb_utf8_stream_decoder;
  import u8d_pkg::*;

  localparam int unsigned PhaseBytes = 350;
  localparam int unsigned QuietLimit = 4000;

  typedef struct packed {
    logic [CpW-1:0]  cp;
    logic [LenW-1:0] len;
    logic            stray;
    logic            bad;
  } char_t;

  typedef struct packed {
    logic [ByteW-1:0] b;
    logic             typed;
    char_t            res;
  } row_t;

  localparam int unsigned DirRowCnt = 24;

  localparam row_t DirRows [DirRowCnt] = '{
    '{8'h00, 1'b1, '{21'h000000, LenOne,   1'b0, 1'b0}},
    '{8'h7f, 1'b1, '{21'h00007f, LenOne,   1'b0, 1'b0}},
    '{8'h80, 1'b1, '{21'h000080, LenOne,   1'b1, 1'b0}},
    '{8'hbf, 1'b1, '{21'h0000bf, LenOne,   1'b1, 1'b0}},
    '{8'hf8, 1'b1, '{21'h0000f8, LenOne,   1'b0, 1'b0}},
    '{8'hff, 1'b1, '{21'h0000ff, LenOne,   1'b0, 1'b0}},
    '{8'hc2, 1'b0, '0},
    '{8'h80, 1'b1, '{21'h000080, LenTwo,   1'b0, 1'b0}},
    '{8'hef, 1'b0, '0},
    '{8'hbf, 1'b0, '0},
    '{8'hbf, 1'b1, '{21'h00ffff, LenThree, 1'b0, 1'b0}},
    '{8'hf4, 1'b0, '0},
    '{8'h8f, 1'b0, '0},
    '{8'hbf, 1'b0, '0},
    '{8'hbf, 1'b0, '0},
    '{8'hf7, 1'b0, '0},
    '{8'hbf, 1'b0, '0},
    '{8'hbf, 1'b0, '0},
    '{8'hbf, 1'b1, '{21'h1fffff, LenFour,  1'b0, 1'b0}},
    '{8'hc3, 1'b0, '0},
    '{8'h41, 1'b0, '0},
    '{8'he2, 1'b0, '0},
    '{8'hc0, 1'b0, '0},
    '{8'h80, 1'b0, '0}
  };

  logic clk_i;
  logic rst_ni;

  u8d_byte_if byte_if ();
  u8d_cp_if   cp_if ();

  utf8_stream_decoder DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_if),
    .cp_o   (cp_if)
  );

  // decoder model state
  logic [1:0]      dec_left = LeftNone;
  logic [CpW-1:0]  dec_acc  = '0;
  logic [LenW-1:0] dec_len  = LenOne;
  logic            dec_bad  = 1'b0;

  char_t       pending_chars [$];
  char_t       head_char;
  int unsigned mismatches     = 0;
  int unsigned bytes_accepted = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned stall_pct      = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void decode_byte(input logic [ByteW-1:0] b, output logic got,
                                      output char_t res);
    got = 1'b0;
    res = '0;
    if (dec_left == LeftNone) begin
      if (b[7:5] == 3'b110) begin
        dec_acc  = CpW'(b[4:0]);
        dec_left = LeftOne;
        dec_len  = LenTwo;
        dec_bad  = 1'b0;
      end else if (b[7:4] == 4'b1110) begin
        dec_acc  = CpW'(b[3:0]);
        dec_left = LeftTwo;
        dec_len  = LenThree;
        dec_bad  = 1'b0;
      end else if (b[7:3] == 5'b11110) begin
        dec_acc  = CpW'(b[2:0]);
        dec_left = LeftThree;
        dec_len  = LenFour;
        dec_bad  = 1'b0;
      end else begin
        got = 1'b1;
        res = '{cp: CpW'(b), len: LenOne, stray: (b[7:6] == ContMarker), bad: 1'b0};
      end
    end else begin
      if (b[7:6] != ContMarker) dec_bad = 1'b1;
      dec_acc  = {dec_acc[CpW-SixW-1:0], b[SixW-1:0]};
      dec_left = dec_left - 2'd1;
      if (dec_left == LeftNone) begin
        got     = 1'b1;
        res     = '{cp: dec_acc, len: dec_len, stray: 1'b0, bad: dec_bad};
        dec_acc = '0;
        dec_len = LenOne;
        dec_bad = 1'b0;
      end
    end
  endfunction

  task automatic push_byte(input logic [ByteW-1:0] b, input logic typed, input char_t typed_res);
    logic  got;
    char_t res;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      byte_if.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    byte_if.valid   <= 1'b1;
    byte_if.byte_in <= b;
    do @(posedge clk_i); while (!byte_if.ready);
    bytes_accepted++;
    decode_byte(b, got, res);
    if (got) pending_chars = {pending_chars, (typed ? typed_res : res)};
  endtask

  task automatic send_char();
    int unsigned      kind;
    int unsigned      len;
    logic             broken;
    logic [ByteW-1:0] lead;
    logic [ByteW-1:0] follow;
    kind   = $urandom_range(99);
    broken = 1'b0;
    len    = 1;
    if (kind < 25) begin
      push_byte(ByteW'($urandom_range(127)), 1'b0, '0);
    end else if (kind < 85) begin
      len = (kind < 45) ? 2 : (kind < 65) ? 3 : 4;
    end else if (kind < 93) begin
      push_byte(ByteW'($urandom_range(255)), 1'b0, '0);
    end else begin
      len    = $urandom_range(2, 4);
      broken = 1'b1;
    end
    if (len > 1) begin
      case (len)
        2:       lead = {3'b110, 5'($urandom_range(31))};
        3:       lead = {4'b1110, 4'($urandom_range(15))};
        default: lead = {5'b11110, 3'($urandom_range(7))};
      endcase
      push_byte(lead, 1'b0, '0);
      for (int unsigned i = 1; i < len; i++) begin
        if (broken && $urandom_range(1) == 1) follow = ByteW'($urandom_range(255));
        else follow = {ContMarker, 6'($urandom_range(63))};
        push_byte(follow, 1'b0, '0);
      end
    end
  endtask

  task automatic drain();
    byte_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_chars.size() != 0);
  endtask

  always @(posedge clk_i) begin
    cp_if.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= QuietLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else if ((byte_if.valid && byte_if.ready) || (cp_if.valid && cp_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (cp_if.valid && cp_if.ready) begin
      if (pending_chars.size() == 0) begin
        $error("code point item with no pending character: cp %h", cp_if.code_point);
        mismatches++;
      end else begin
        head_char = pending_chars.pop_front();
        if (cp_if.code_point !== head_char.cp) begin
          $error("code_point: expected %h, got %h", head_char.cp, cp_if.code_point);
          mismatches++;
        end
        if (cp_if.char_length !== head_char.len) begin
          $error("char_length: expected %0d, got %0d", head_char.len, cp_if.char_length);
          mismatches++;
        end
        if (cp_if.stray_lead !== head_char.stray) begin
          $error("stray_lead: expected %b, got %b", head_char.stray, cp_if.stray_lead);
          mismatches++;
        end
        if (cp_if.bad_continuation !== head_char.bad) begin
          $error("bad_continuation: expected %b, got %b", head_char.bad,
                 cp_if.bad_continuation);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int unsigned target;
    rst_ni          <= 1'b0;
    byte_if.valid   <= 1'b0;
    byte_if.byte_in <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int unsigned i = 0; i < DirRowCnt; i++) begin
      push_byte(DirRows[i].b, DirRows[i].typed, DirRows[i].res);
    end
    drain();

    for (int unsigned phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 77; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 77; end
        default: begin send_idle_pct = 28; stall_pct = 28; end
      endcase
      target = bytes_accepted + PhaseBytes;
      while (bytes_accepted < target) send_char();
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/u8d_pkg.sv
design/u8d_stream_if.sv
design/u8d_front.sv
design/u8d_queue.sv
design/u8d_back.sv
design/utf8_stream_decoder.sv
verif/tb_utf8_stream_decoder.sv
